// ===== design/nco_pkg.sv =====
package nco_pkg;

   localparam int MaxIterations = 64;
   localparam int DataWidth = 32;
   localparam int StepWidth = 6;
   localparam int MinStepWidth = 31;
   localparam int LimitWidth = 7;
   localparam logic [30:0] MinStepReset = 31'd16777;
   localparam logic [6:0] LimitReset = 7'd64;
   localparam logic signed [31:0] QOne = 32'sd16777216;

   localparam logic [0:0] AddrMinStep = 1'b0;
   localparam logic [0:0] AddrLimit = 1'b1;

   // Operation codes for the shared multiplier.
   typedef enum logic [1:0] {
      MulRound = 2'd0,
      MulRaw = 2'd1
   } mul_op_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      begin
         if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
         end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
         end else begin
            r = v[31:0];
         end
         return r;
      end
   endfunction

endpackage

// ===== design/newton_cubic_orbit.sv =====
// Relaxed Newton orbit for z^3 - 1 in signed Q8.24. Each start point taken on the req channel
// produces up to iteration_limit segment transactions on the rsp channel (from, to, step
// number, fault, last). A start point with a zero coordinate, or a limit of zero, is taken
// and produces none. Every iteration computes its products through the one shared 32x32
// multiplier, checks the divisor, runs two bit-serial divisions (real part, then imaginary
// part), checks for convergence and offers the segment until it is taken. An iteration whose
// divisor is zero ends the run with a fault segment and no division. req_stall is high from
// the cycle after a start point that produces segments is taken until its last segment has
// been taken.
module newton_cubic_orbit #(
   parameter int MAX_ITERATIONS = nco_pkg::MaxIterations
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_start_re,
   input  logic signed [31:0]  req_start_im,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_from_re,
   output logic signed [31:0]  rsp_from_im,
   output logic signed [31:0]  rsp_to_re,
   output logic signed [31:0]  rsp_to_im,
   output logic [5:0]          rsp_step_number,
   output logic                rsp_div_fault,
   output logic                rsp_last,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import nco_pkg::*;

   typedef enum logic [6:0] {
      StIdle = 7'b000_0001,
      StMul  = 7'b000_0010,
      StDen  = 7'b000_0100,
      StDivR = 7'b000_1000,
      StDivI = 7'b001_0000,
      StWait = 7'b010_0000,
      StEmit = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;
   logic [30:0] min_step_ff;
   logic [6:0] limit_ff;
   logic signed [31:0] x_ff, y_ff, sr_ff, si_ff, nr_ff, ni_ff, dr_ff, di_ff;
   logic signed [31:0] zr_ff, zi_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] pr0_ff, pr1_ff, pi0_ff, pi1_ff;
   logic [63:0] d2_ff;
   logic [3:0] ph_ff;
   logic [5:0] n_ff;
   logic [6:0] lim_run_ff;
   logic fault_ff, last_ff, wr;
   logic signed [31:0] ma, mb;
   mul_op_type mop;
   logic signed [63:0] prod;
   logic div_start, div_done, div_neg_ff;
   logic [63:0] div_mag;
   logic [32:0] quot;
   logic signed [65:0] sum66;
   logic signed [32:0] qs;
   logic signed [32:0] ddr, ddi;
   logic signed [32:0] thr;
   logic [6:0] max_lim;
   logic start_ok;
   logic converged;

   assign max_lim = 7'(MAX_ITERATIONS);
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      case (csr_paddr[2])
         AddrMinStep: csr_prdata = {1'b0, min_step_ff};
         AddrLimit: csr_prdata = {25'd0, limit_ff};
         default: csr_prdata = '0;
      endcase
   end

   // Multiplier operand schedule, one product per phase; each product is captured in the
   // phase after it is issued.
   always_comb begin
      ma = x_ff;
      mb = x_ff;
      mop = MulRound;
      case (ph_ff)
         4'd0: begin ma = x_ff;  mb = x_ff; end
         4'd1: begin ma = y_ff;  mb = y_ff; end
         4'd2: begin ma = x_ff;  mb = y_ff; end
         4'd3: begin ma = sr_ff; mb = x_ff; end
         4'd4: begin ma = si_ff; mb = y_ff; end
         4'd5: begin ma = sr_ff; mb = y_ff; end
         4'd6: begin ma = si_ff; mb = x_ff; end
         4'd7: begin ma = dr_ff; mb = dr_ff; mop = MulRaw; end
         4'd8: begin ma = di_ff; mb = di_ff; mop = MulRaw; end
         4'd9: begin ma = nr_ff; mb = dr_ff; mop = MulRaw; end
         4'd10: begin ma = ni_ff; mb = di_ff; mop = MulRaw; end
         4'd11: begin ma = ni_ff; mb = dr_ff; mop = MulRaw; end
         4'd12: begin ma = nr_ff; mb = di_ff; mop = MulRaw; end
         default: begin ma = x_ff; mb = x_ff; end
      endcase
   end

   nco_mul u_mul (.clock(clock), .a(ma), .b(mb), .round_en(mop == MulRound), .prod(prod));
   nco_div u_div (.clock(clock), .reset(reset), .start(div_start), .mag(div_mag),
      .den(d2_ff), .done(div_done), .quot(quot));

   always_comb begin
      // The real-part numerator feeds the first division, the imaginary one the second.
      if (state_ff == StDen) begin
         sum66 = 66'(pr0_ff) + 66'(pr1_ff);
      end else begin
         sum66 = 66'(pi0_ff) + 66'(pi1_ff);
      end
      div_mag = sum66[65] ? 64'(-sum66) : sum66[63:0];
      if (div_neg_ff) begin
         qs = (quot > 33'h0_8000_0000) ? -33'sh0_8000_0000 : -$signed(quot);
      end else begin
         qs = (quot > 33'h0_7fff_ffff) ? 33'sh0_7fff_ffff : $signed(quot);
      end
      ddr = 33'(zr_ff) - 33'(x_ff);
      ddi = 33'(zi_ff) - 33'(y_ff);
      thr = {2'b00, min_step_ff};
      converged = ddr > -thr && ddr < thr && ddi > -thr && ddi < thr;
      start_ok = req_start_re != 32'sd0 && req_start_im != 32'sd0 && limit_ff != 7'd0;
      div_start = (state_ff == StDen && d2_ff != 64'd0) || (state_ff == StDivR && div_done);
   end

   assign req_stall = (state_ff != StIdle);
   assign rsp_valid = (state_ff == StEmit);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: if (req_valid && start_ok) state_in = StMul;
         StMul: if (ph_ff == 4'd13) state_in = StDen;
         StDen: state_in = (d2_ff == 64'd0) ? StEmit : StDivR;
         StDivR: if (div_done) state_in = StDivI;
         StDivI: if (div_done) state_in = StWait;
         StWait: state_in = StEmit;
         StEmit: if (!rsp_stall) state_in = last_ff ? StIdle : StMul;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         min_step_ff <= MinStepReset;
         limit_ff <= LimitReset;
      end else begin
         state_ff <= state_in;
         if (wr) begin
            case (csr_paddr[2])
               AddrMinStep: min_step_ff <= csr_pwdata[30:0];
               AddrLimit: limit_ff <= csr_pwdata[6:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         StIdle: begin
            x_ff <= req_start_re;
            y_ff <= req_start_im;
            n_ff <= '0;
            ph_ff <= '0;
            lim_run_ff <= (limit_ff > max_lim) ? max_lim : limit_ff;
         end
         StMul: begin
            ph_ff <= ph_ff + 4'd1;
            case (ph_ff)
               4'd1: acc_ff <= prod;
               4'd2: sr_ff <= sat32(66'(acc_ff) - 66'(prod));
               4'd3: si_ff <= sat32(66'(prod) * 66'sd2);
               4'd4: acc_ff <= prod;
               4'd5: begin
                  nr_ff <= sat32(66'(sat32(66'(acc_ff) - 66'(prod))) - 66'(QOne));
                  dr_ff <= sat32(66'(sr_ff) * 66'sd2);
                  di_ff <= sat32(66'(si_ff) * 66'sd2);
               end
               4'd6: acc_ff <= prod;
               4'd7: ni_ff <= sat32(66'(acc_ff) + 66'(prod));
               4'd8: d2_ff <= 64'(prod);
               4'd9: d2_ff <= d2_ff + 64'(prod);
               4'd10: pr0_ff <= prod;
               4'd11: pr1_ff <= prod;
               4'd12: pi0_ff <= prod;
               4'd13: pi1_ff <= -prod;
               default: ;
            endcase
         end
         StDen: begin
            div_neg_ff <= sum66[65];
            if (d2_ff == 64'd0) begin
               fault_ff <= 1'b1;
               last_ff <= 1'b1;
               zr_ff <= '0;
               zi_ff <= '0;
            end else begin
               fault_ff <= 1'b0;
            end
         end
         StDivR: begin
            if (div_done) begin
               zr_ff <= sat32(66'(x_ff) - 66'(qs));
               div_neg_ff <= sum66[65];
            end
         end
         StDivI: begin
            if (div_done) zi_ff <= sat32(66'(y_ff) - 66'(qs));
         end
         StWait: begin
            last_ff <= converged || (({1'b0, n_ff} + 7'd1) == lim_run_ff);
         end
         StEmit: begin
            if (!rsp_stall && !last_ff) begin
               x_ff <= zr_ff;
               y_ff <= zi_ff;
               n_ff <= n_ff + 6'd1;
               ph_ff <= '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_from_re = x_ff;
   assign rsp_from_im = y_ff;
   assign rsp_to_re = zr_ff;
   assign rsp_to_im = zi_ff;
   assign rsp_step_number = n_ff;
   assign rsp_div_fault = fault_ff;
   assign rsp_last = last_ff;
endmodule

// ===== design/nco_mul.sv =====
// Shared signed multiplier: 32x32 product, registered, optionally rounded to Q8.24.
module nco_mul (
   input  logic                clock,
   input  logic signed [31:0]  a,
   input  logic signed [31:0]  b,
   input  logic                round_en,
   output logic signed [63:0]  prod
);
   import nco_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [63:0] raw;

   always_comb begin
      raw = a * b;
      if (round_en) begin
         prod_in = (raw + 64'sd8388608) >>> 24;
      end else begin
         prod_in = raw;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

// ===== design/nco_div.sv =====
// Restoring divider: magnitude * 2^24 / den, one quotient bit per cycle.
// Quotient is clipped at 2^32 which the caller saturates.
module nco_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  mag,
   input  logic [63:0]  den,
   output logic         done,
   output logic [32:0]  quot
);
   import nco_pkg::*;

   logic [87:0] num_ff, num_in;
   logic [64:0] rem_ff, rem_in;
   logic [32:0] q_ff, q_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic        sat_q;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[63:0], num_ff[87]};
      sat_q = q_ff[32];
      if (start) begin
         num_in = {mag, 24'd0};
         rem_in = '0;
         q_in = '0;
         cnt_in = 7'd88;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[86:0], 1'b0};
         if (!sat_q) begin
            if (trial >= {1'b0, den}) begin
               rem_in = trial - {1'b0, den};
               q_in = {q_ff[31:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in = {q_ff[31:0], 1'b0};
            end
            // Once the quotient reaches 2^32 it saturates.
            if (q_ff[31]) begin
               q_in = 33'h1_0000_0000;
            end
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== design/nco_checker.sv =====
module nco_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_last,
   input logic        rsp_div_fault,
   input logic [5:0]  rsp_step_number
);
   a_fault_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_fault |-> rsp_last) else $error("fault without last");
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input open during output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_step_number) &&
      $stable(rsp_last) && $stable(rsp_div_fault)) else $error("stalled segment changed");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid) else $error("segment after last");
endmodule

bind newton_cubic_orbit nco_checker u_nco_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_last(rsp_last),
   .rsp_div_fault(rsp_div_fault), .rsp_step_number(rsp_step_number));

// ===== test/newton_cubic_orbit_tb.sv =====
module newton_cubic_orbit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nco_pkg::*;

   typedef struct packed {
      logic signed [31:0] from_re;
      logic signed [31:0] from_im;
      logic signed [31:0] to_re;
      logic signed [31:0] to_im;
      logic [5:0]         step_number;
      logic               div_fault;
      logic               last;
   } segment_type;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      bit                 drain_first;
   } start_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_start_re = '0;
   logic signed [31:0] req_start_im = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_from_re, rsp_from_im, rsp_to_re, rsp_to_im;
   logic [5:0] rsp_step_number;
   logic rsp_div_fault, rsp_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   start_point_type pending_points[$];
   segment_type     orbit_segments[$];
   logic [30:0]  cur_min_step = MinStepReset;
   logic [6:0]   cur_limit = LimitReset;
   int           mismatches = 0;
   int           send_gap = 0;
   int           recv_gap = 0;
   bit           steady = 1'b0;
   bit           req_taken = 1'b0;

   newton_cubic_orbit i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 23)) >>> 24;
   endfunction

   // Exact (p1 + p2) * 2^24 / d2 truncated toward zero, then saturated.
   function automatic longint qdiv(longint p1, longint p2, logic [63:0] d2);
      logic [63:0] mag, q, r;
      bit neg;
      longint s;
      if (p1 >= 0 && p2 >= 0) begin
         neg = 1'b0;
         mag = 64'(p1) + 64'(p2);
      end else if (p1 < 0 && p2 < 0) begin
         neg = 1'b1;
         mag = 64'(-p1) + 64'(-p2);
      end else begin
         s = p1 + p2;
         neg = s < 0;
         mag = s < 0 ? 64'(-s) : 64'(s);
      end
      q = mag / d2;
      r = mag % d2;
      if (q >= 256) begin
         q = 64'd1 << 32;
      end else begin
         for (int i = 0; i < 24; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d2) begin
               r = r - d2;
               q[0] = 1'b1;
            end
         end
      end
      if (neg) begin
         if (q > 64'h80000000) q = 64'h80000000;
         return -longint'(q);
      end
      if (q > 64'h7fffffff) q = 64'h7fffffff;
      return longint'(q);
   endfunction

   task automatic predict_orbit(start_point_type p);
      longint x, y, thr, sr, si, cr, ci, nr, ni, dr, di, qr, qi, zr, zi, ddr, ddi;
      logic [63:0] d2;
      int lim;
      segment_type seg;
      x = p.re;
      y = p.im;
      thr = cur_min_step;
      lim = cur_limit > MaxIterations ? MaxIterations : cur_limit;
      if (x == 0 || y == 0) return;
      for (int n = 0; n < lim; n++) begin
         sr = clamp32(qmul(x, x) - qmul(y, y));
         si = clamp32(2 * qmul(x, y));
         cr = clamp32(qmul(sr, x) - qmul(si, y));
         ci = clamp32(qmul(sr, y) + qmul(si, x));
         nr = clamp32(cr - QOne);
         ni = ci;
         dr = clamp32(2 * sr);
         di = clamp32(2 * si);
         seg.from_re = x[31:0];
         seg.from_im = y[31:0];
         seg.step_number = n[5:0];
         d2 = 64'(dr * dr) + 64'(di * di);
         if (d2 == 0) begin
            seg.to_re = '0;
            seg.to_im = '0;
            seg.div_fault = 1'b1;
            seg.last = 1'b1;
            orbit_segments = {orbit_segments, seg};
            return;
         end
         qr = qdiv(nr * dr, ni * di, d2);
         qi = qdiv(ni * dr, (-nr) * di, d2);
         zr = clamp32(x - qr);
         zi = clamp32(y - qi);
         ddr = zr - x;
         ddi = zi - y;
         seg.to_re = zr[31:0];
         seg.to_im = zi[31:0];
         seg.div_fault = 1'b0;
         seg.last = (ddr > -thr && ddr < thr && ddi > -thr && ddi < thr) || (n + 1 == lim);
         orbit_segments = {orbit_segments, seg};
         if (seg.last) return;
         x = zr;
         y = zi;
      end
   endtask

   // Mostly short gaps, now and then a long one; none at all in steady phases.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Sample at the rising edge: accepted start points and result transactions.
   always @(posedge clock) begin
      segment_type got, want;
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1'b1;
         predict_orbit(pending_points.pop_front());
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_from_re, rsp_from_im, rsp_to_re, rsp_to_im, rsp_step_number,
                 rsp_div_fault, rsp_last};
         if (orbit_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected segment from (%0d,%0d) step %0d", got.from_re,
                        got.from_im, got.step_number);
         end else begin
            want = orbit_segments.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"segment mismatch: expected from (%0d,%0d) to (%0d,%0d)",
                            " step %0d fault %0d last %0d"},
                           want.from_re, want.from_im, want.to_re, want.to_im,
                           want.step_number, want.div_fault, want.last);
                  $display({"                  actual   from (%0d,%0d) to (%0d,%0d)",
                            " step %0d fault %0d last %0d"},
                           got.from_re, got.from_im, got.to_re, got.to_im,
                           got.step_number, got.div_fault, got.last);
               end
            end
         end
      end
   end

   // Drive at the falling edge. The front of pending_points is what is on the port.
   always @(negedge clock) begin
      bit next_valid;
      bit was_taken;
      if (!reset) begin
         was_taken = req_taken;
         req_taken = 1'b0;
         next_valid = req_valid && !was_taken;
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_points.size() > 0 && (!pending_points[0].drain_first ||
                         orbit_segments.size() == 0)) begin
               req_start_re <= pending_points[0].re;
               req_start_im <= pending_points[0].im;
               next_valid = 1'b1;
               send_gap = idle_cycles();
            end
         end
         req_valid <= next_valid;
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            recv_gap = idle_cycles();
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (addr == 3'd0) cur_min_step = data[30:0];
      else if (addr == 3'd4) cur_limit = data[6:0];
   endtask

   task automatic wait_drained();
      wait (pending_points.size() == 0 && !req_valid && orbit_segments.size() == 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic add_point(logic signed [31:0] re, logic signed [31:0] im, bit drain);
      start_point_type p;
      p.re = re;
      p.im = im;
      p.drain_first = drain;
      pending_points.push_back(p);
   endtask

   function automatic logic signed [31:0] random_coord();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $signed(32'($urandom_range(2 * QOne, 0))) - 2 * QOne + 32'sd1;
      if (r < 75) return $signed(32'($urandom_range(32'h07ffffff, 0))) - 32'sh04000000;
      if (r < 97) return $signed($urandom);
      return '0;
   endfunction

   task automatic random_points(int count);
      logic signed [31:0] re, im;
      int done;
      done = 0;
      while (done < count) begin
         re = random_coord();
         im = random_coord();
         add_point(re, im, $urandom_range(39) == 0);
         if (re != 0 && im != 0) done++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Defaults after reset: extremes, zero coordinates, tiny points and near roots.
      add_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
      add_point(32'sh80000000, 32'sh80000000, 1'b0);
      add_point(32'sh80000000, 32'sh7fffffff, 1'b0);
      add_point(32'sh7fffffff, 32'sh80000000, 1'b0);
      add_point(32'sh80000000, 32'sd1, 1'b0);
      add_point(32'sd1, 32'sd1, 1'b0);
      add_point(-32'sd1, 32'sd1, 1'b0);
      add_point(32'sd0, 32'sd5, 1'b0);
      add_point(32'sd5, 32'sd0, 1'b0);
      add_point(32'sd0, 32'sd0, 1'b0);
      add_point(QOne, 32'sd1, 1'b1);
      add_point(-QOne / 2, 32'sd14529495, 1'b0);
      add_point(-QOne / 2, -32'sd14529495, 1'b0);
      add_point(32'sd4096, -32'sd4096, 1'b0);
      add_point(-32'sd2, 32'sd3, 1'b0);
      add_point(2 * QOne, 3 * QOne, 1'b0);
      wait_drained();

      csr_write(3'd4, 32'd0);
      csr_write(3'd0, 32'd0);
      random_points(8);
      wait_drained();

      csr_write(3'd4, 32'd1);
      csr_write(3'd0, 32'hffffffff);
      steady = 1'b1;
      random_points(30);
      wait_drained();
      steady = 1'b0;
      random_points(30);
      wait_drained();

      csr_write(3'd4, 32'd100);
      csr_write(3'd0, 32'h00100000);
      random_points(40);
      wait_drained();

      for (int k = 0; k < 5; k++) begin
         csr_write(3'd4, $urandom_range(8, 2));
         csr_write(3'd0, $urandom & 32'h7fffffff >> $urandom_range(30, 0));
         random_points(30);
         wait_drained();
      end

      csr_write(3'd4, 32'd127);
      csr_write(3'd0, 32'd0);
      random_points(10);
      wait_drained();

      csr_write(3'd4, 32'd64);
      csr_write(3'd0, 32'h7fffffff);
      random_points(20);
      wait_drained();

      if (mismatches == 0 && orbit_segments.size() == 0) begin
         $display("newton_cubic_orbit regression: pass");
      end else begin
         $display("newton_cubic_orbit regression: fail");
      end
      $finish;
   end

   initial begin
      #300ms;
      $display("newton_cubic_orbit regression: fail");
      $finish;
   end

endmodule
